### rtl/ejst_pkg.sv
// ----------------------------------------------------------------------------
// ejst_pkg
// Shared widths, register indexes, stage control types and saturating adders
// for the exact two-way join size tracker.
// ----------------------------------------------------------------------------
package ejst_pkg;

    localparam int SID_W      = 8;
    localparam int KEY_W      = 12;
    localparam int UPD_W      = 16;
    localparam int CNT_W      = 32;
    localparam int PROD_W     = UPD_W + CNT_W;
    localparam int EST_W      = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_STREAM  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_STREAM = 8'd1;

    localparam logic [SID_W-1:0] FIRST_STREAM_RST  = 8'd0;
    localparam logic [SID_W-1:0] SECOND_STREAM_RST = 8'd1;

    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
    localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

    // control of the item sitting in the table read stage
    typedef struct packed {
        logic valid;
        logic matched;
        logic to_first;
    } t_stage_ctl;

    // table write strobes from the update unit
    typedef struct packed {
        logic we_first;
        logic we_second;
    } t_wr_ctl;

    function automatic logic signed [CNT_W-1:0] sat_cnt_add(
        input logic signed [CNT_W-1:0] a,
        input logic signed [UPD_W-1:0] d
    );
        logic signed [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(d);
        if (s[CNT_W] != s[CNT_W-1]) begin
            return s[CNT_W] ? CNT_MIN : CNT_MAX;
        end
        return s[CNT_W-1:0];
    endfunction

    function automatic logic signed [EST_W-1:0] sat_est_add(
        input logic signed [EST_W-1:0]  e,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [EST_W:0] s;
        s = (EST_W+1)'(e) + (EST_W+1)'(p);
        if (s[EST_W] != s[EST_W-1]) begin
            return s[EST_W] ? EST_MIN : EST_MAX;
        end
        return s[EST_W-1:0];
    endfunction

endpackage

### rtl/ejst_ram.sv
// ----------------------------------------------------------------------------
// ejst_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ejst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ejst_upd.sv
// ----------------------------------------------------------------------------
// ejst_upd
// Update unit: saturating counter update for the write-back, product of the
// update with the other table's counter, and the saturating join size
// accumulator that drives the result ports.
// ----------------------------------------------------------------------------
module ejst_upd
    import ejst_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_stage_ctl               i_ctl,
    input  logic signed [UPD_W-1:0]  i_upd,
    input  logic signed [CNT_W-1:0]  i_rd_first,
    input  logic signed [CNT_W-1:0]  i_rd_second,
    output t_wr_ctl                  o_wr,
    output logic signed [CNT_W-1:0]  o_wr_data,
    output logic                     o_valid,
    output logic signed [EST_W-1:0]  o_join_size,
    output logic                     o_matched
);

    logic signed [CNT_W-1:0]  w_own;
    logic signed [CNT_W-1:0]  w_other;
    logic signed [PROD_W-1:0] n_prod;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p_valid;
    logic                     r_p_matched;
    logic signed [EST_W-1:0]  r_estimate;
    logic                     r_valid;
    logic                     r_matched;

    assign w_own     = i_ctl.to_first ? i_rd_first  : i_rd_second;
    assign w_other   = i_ctl.to_first ? i_rd_second : i_rd_first;
    assign o_wr_data = sat_cnt_add(w_own, i_upd);

    assign o_wr.we_first  = i_ctl.valid & i_ctl.matched & i_ctl.to_first;
    assign o_wr.we_second = i_ctl.valid & i_ctl.matched & ~i_ctl.to_first;

    // unmatched items add nothing to the estimate
    always_comb begin
        if (i_ctl.matched) begin
            n_prod = PROD_W'(i_upd) * PROD_W'(w_other);
        end else begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_p_matched <= 1'b0;
            r_estimate  <= '0;
            r_valid     <= 1'b0;
            r_matched   <= 1'b0;
        end else begin
            r_p_valid   <= i_ctl.valid;
            r_p_matched <= i_ctl.matched;
            if (r_p_valid) begin
                r_estimate <= sat_est_add(r_estimate, r_prod);
            end
            r_valid   <= r_p_valid;
            r_matched <= r_p_matched;
        end
    end

    assign o_valid     = r_valid;
    assign o_matched   = r_matched;
    assign o_join_size = r_estimate;

endmodule

### rtl/exact_two_way_join_size_tracker.sv
// ----------------------------------------------------------------------------
// exact_two_way_join_size_tracker
// Exact join size of two update streams from two key-indexed counter tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_stream_id, i_key, i_update and pulse start while busy is
//   low; the item is taken at that clock edge.
//   Result: o_valid is high for exactly one cycle with o_join_size (estimate
//   after the item, saturating) and o_matched. The receiver cannot stall.
//   Configuration: i_cfg_we with i_cfg_idx 0 (first stream) or 1 (second
//   stream) and i_cfg_data; other indexes are ignored. Write only while idle.
// Timing:
//   An item is accepted at a clock edge that also registers its table read;
//   its result goes through the product and the estimate registers to the
//   ports. busy is high for one cycle after each accept, so no new item is
//   taken before the write-back lands, and its table read sees the new count.
// Reset:
//   i_rst_n low (synchronous) resets the control and stream registers and
//   the estimate; then a clearing pass zeroes every entry of both tables,
//   with busy high. Configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
module exact_two_way_join_size_tracker
    import ejst_pkg::*;
#(
    parameter int KEY_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [SID_W-1:0]             i_stream_id,
    input  logic [KEY_W-1:0]             i_key,
    input  logic signed [UPD_W-1:0]      i_update,
    output logic                         o_valid,
    output logic signed [EST_W-1:0]      o_join_size,
    output logic                         o_matched
);

    localparam int DEPTH = 2 ** KEY_BITS;

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    logic                    r_state;
    logic [KEY_BITS-1:0]     r_clr_addr;
    logic [SID_W-1:0]        r_first_stream;
    logic [SID_W-1:0]        r_second_stream;
    t_stage_ctl              r_ctl;
    logic [KEY_BITS-1:0]     r_idx;
    logic signed [UPD_W-1:0] r_upd;

    logic                    w_clearing;
    logic                    w_accept;
    logic                    w_hit_first;
    logic                    w_hit_second;
    logic [KEY_BITS-1:0]     w_idx;
    t_wr_ctl                 w_wr;
    logic signed [CNT_W-1:0] w_wr_data;
    logic signed [CNT_W-1:0] w_rd_first;
    logic signed [CNT_W-1:0] w_rd_second;
    logic [KEY_BITS-1:0]     w_waddr;
    logic [CNT_W-1:0]        w_wdata;

    assign w_clearing   = (r_state == ST_CLEAR);
    assign busy         = w_clearing | r_ctl.valid;
    assign w_accept     = start & ~busy;
    assign w_idx        = KEY_BITS'(i_key);
    assign w_hit_first  = (i_stream_id == r_first_stream);
    assign w_hit_second = ~w_hit_first & (i_stream_id == r_second_stream);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= w_idx;
            r_upd <= i_update;
        end
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr_addr      <= '0;
            r_first_stream  <= FIRST_STREAM_RST;
            r_second_stream <= SECOND_STREAM_RST;
            r_ctl           <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIRST_STREAM) begin
                    r_first_stream <= i_cfg_data;
                end else if (i_cfg_idx == CFG_SECOND_STREAM) begin
                    r_second_stream <= i_cfg_data;
                end
            end
            r_ctl.valid    <= w_accept;
            r_ctl.matched  <= w_hit_first | w_hit_second;
            r_ctl.to_first <= w_hit_first;
        end
    end

    // clearing pass owns the write port until it is done
    assign w_waddr = w_clearing ? r_clr_addr : r_idx;
    assign w_wdata = w_clearing ? '0 : w_wr_data;

    ejst_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (w_clearing | w_wr.we_first),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_rd_first)
    );

    ejst_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (w_clearing | w_wr.we_second),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_rd_second)
    );

    ejst_upd u_upd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_ctl),
        .i_upd       (r_upd),
        .i_rd_first  (w_rd_first),
        .i_rd_second (w_rd_second),
        .o_wr        (w_wr),
        .o_wr_data   (w_wr_data),
        .o_valid     (o_valid),
        .o_join_size (o_join_size),
        .o_matched   (o_matched)
    );

endmodule

### tb/sv/tb_exact_two_way_join_size_tracker.sv
// ----------------------------------------------------------------------------
// tb_exact_two_way_join_size_tracker
// Self-checking bench for the exact two-way join size tracker. A directed
// table covers reset settings, field extremes, unmatched records, equal
// stream ids and ignored register writes. Random traffic then runs under
// several stream settings. Every result is checked against a behavioral
// model of the counter tables and the join size, or a typed expected value.
// ----------------------------------------------------------------------------
module tb_exact_two_way_join_size_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    import ejst_pkg::*;

    localparam int TABLE_DEPTH   = 1 << KEY_W;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LIMIT_CYCLES  = 200_000;
    localparam int N_PHASES      = 5;
    localparam int PHASE_ITEMS   = 150;
    localparam int TAIL_ITEMS    = 40;
    localparam int N_HOT_KEYS    = 16;

    localparam longint COUNT_HI = 64'sd2147483647;
    localparam longint COUNT_LO = -COUNT_HI - 1;

    // indexes outside the register map, written to check they are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 8'hFF;

    localparam logic [SID_W-1:0] PHASE_FIRST [N_PHASES] =
        '{8'd3, 8'd255, 8'd17, 8'd128, 8'd0};
    localparam logic [SID_W-1:0] PHASE_SECOND [N_PHASES] =
        '{8'd200, 8'd0, 8'd17, 8'd127, 8'd255};

    typedef struct packed {
        logic signed [EST_W-1:0] join_size;
        logic                    matched;
    } t_join_res;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_data;
        logic [SID_W-1:0]         sid;
        logic [KEY_W-1:0]         key;
        logic signed [UPD_W-1:0]  upd;
        logic                     typed;
        logic signed [EST_W-1:0]  exp_join;
        logic                     exp_matched;
    } t_plan_row;

    localparam int PLAN_LEN = 24;

    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // reset settings: stream 0 feeds the first table, stream 1 the second
        '{ROW_ITEM, 8'd0, 8'd0, 8'd2,   12'd0,    16'sd5,    1'b1, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd0,   12'd0,    16'sh7FFF, 1'b1, 64'sd0, 1'b1},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd1,   12'd0,    16'sh8000, 1'b1,
          -64'sd1073709056, 1'b1},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd1,   12'd4095, 16'sh7FFF, 1'b1,
          -64'sd1073709056, 1'b1},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd0,   12'd4095, 16'sh8000, 1'b1,
          -64'sd2147418112, 1'b1},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd255, 12'd2730, 16'sh8000, 1'b1,
          -64'sd2147418112, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd0,   12'd2730, 16'sh0000, 1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd1,   12'd1365, 16'sh5555, 1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd0,   12'd1365, 16'shAAAA, 1'b0, 64'sd0, 1'b0},
        // same id in both registers: matches go to the first table only
        '{ROW_CFG, CFG_FIRST_STREAM,  8'hFF, 8'd0, 12'd0, 16'sd0, 1'b0, 64'sd0, 1'b0},
        '{ROW_CFG, CFG_SECOND_STREAM, 8'hFF, 8'd0, 12'd0, 16'sd0, 1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd255, 12'd0,    16'sd1,    1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd255, 12'd4095, 16'shFFFF, 1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd0,   12'd0,    16'sd7,    1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd1,   12'd0,    16'sd7,    1'b0, 64'sd0, 1'b0},
        // writes outside the register map change nothing
        '{ROW_CFG, CFG_IDX_UNUSED_LO, 8'd0,  8'd0, 12'd0, 16'sd0, 1'b0, 64'sd0, 1'b0},
        '{ROW_CFG, CFG_IDX_UNUSED_HI, 8'd1,  8'd0, 12'd0, 16'sd0, 1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd0,   12'd0,    16'sd3,    1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd255, 12'd0,    16'sh8000, 1'b0, 64'sd0, 1'b0},
        // swapped ids
        '{ROW_CFG, CFG_FIRST_STREAM,  8'd1,  8'd0, 12'd0, 16'sd0, 1'b0, 64'sd0, 1'b0},
        '{ROW_CFG, CFG_SECOND_STREAM, 8'd0,  8'd0, 12'd0, 16'sd0, 1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd0,   12'd0,    16'sh7FFF, 1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd1,   12'd4095, 16'sh7FFF, 1'b0, 64'sd0, 1'b0},
        '{ROW_ITEM, 8'd0, 8'd0, 8'd128, 12'd2048, 16'shFFFF, 1'b0, 64'sd0, 1'b0}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic [SID_W-1:0]        i_stream_id;
    logic [KEY_W-1:0]        i_key;
    logic signed [UPD_W-1:0] i_update;
    logic                    o_valid;
    logic signed [EST_W-1:0] o_join_size;
    logic                    o_matched;

    // model state
    logic [SID_W-1:0]        cfg_first_sid;
    logic [SID_W-1:0]        cfg_second_sid;
    logic signed [CNT_W-1:0] first_freq [TABLE_DEPTH];
    logic signed [CNT_W-1:0] second_freq [TABLE_DEPTH];
    logic signed [EST_W-1:0] join_est;

    t_join_res        pending_joins [$];
    logic [KEY_W-1:0] hot_keys [N_HOT_KEYS];
    int               errors;
    int unsigned      cycles;

    exact_two_way_join_size_tracker #(
        .KEY_BITS (KEY_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_stream_id (i_stream_id),
        .i_key       (i_key),
        .i_update    (i_update),
        .o_valid     (o_valid),
        .o_join_size (o_join_size),
        .o_matched   (o_matched)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_join_res predict_join(
        input logic [SID_W-1:0]        sid,
        input logic [KEY_W-1:0]        key,
        input logic signed [UPD_W-1:0] upd
    );
        t_join_res             res;
        logic                  to_first;
        longint                own_sum;
        longint                other_cnt;
        logic signed [EST_W:0] est_sum;
        to_first    = (sid == cfg_first_sid);
        res.matched = to_first || (sid == cfg_second_sid);
        if (res.matched) begin
            own_sum   = to_first ? longint'(first_freq[key]) : longint'(second_freq[key]);
            other_cnt = to_first ? longint'(second_freq[key]) : longint'(first_freq[key]);
            own_sum   = own_sum + longint'(upd);
            if (own_sum > COUNT_HI) begin
                own_sum = COUNT_HI;
            end else if (own_sum < COUNT_LO) begin
                own_sum = COUNT_LO;
            end
            if (to_first) begin
                first_freq[key] = own_sum[CNT_W-1:0];
            end else begin
                second_freq[key] = own_sum[CNT_W-1:0];
            end
            // product fits in 48 bits; one guard bit catches the overflow
            est_sum = join_est;
            est_sum = est_sum + (longint'(upd) * other_cnt);
            if (est_sum[EST_W] != est_sum[EST_W-1]) begin
                join_est = est_sum[EST_W] ? EST_MIN : EST_MAX;
            end else begin
                join_est = est_sum[EST_W-1:0];
            end
        end
        res.join_size = join_est;
        return res;
    endfunction

    // hold start until the block takes the item, then queue its result
    task automatic offer_item(
        input logic [SID_W-1:0]        sid,
        input logic [KEY_W-1:0]        key,
        input logic signed [UPD_W-1:0] upd,
        input int                      max_gap,
        input logic                    use_typed,
        input t_join_res               typed_res
    );
        int        gap;
        t_join_res res;
        gap = $urandom_range(max_gap, 0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_stream_id <= sid;
        i_key       <= key;
        i_update    <= upd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res = predict_join(sid, key, upd);
        pending_joins.push_back(use_typed ? typed_res : res);
    endtask

    task automatic offer_random_item(input int max_gap);
        int                      pick;
        logic [SID_W-1:0]        sid;
        logic [KEY_W-1:0]        key;
        logic signed [UPD_W-1:0] upd;
        pick = $urandom_range(9, 0);
        if (pick < 4) begin
            sid = cfg_first_sid;
        end else if (pick < 8) begin
            sid = cfg_second_sid;
        end else begin
            sid = SID_W'($urandom);
        end
        // mostly a small key pool so the two tables meet on the same keys
        key  = ($urandom_range(3, 0) == 0) ? KEY_W'($urandom)
                                           : hot_keys[$urandom_range(N_HOT_KEYS-1, 0)];
        pick = $urandom_range(9, 0);
        if (pick < 5) begin
            upd = UPD_W'($urandom);
        end else if (pick < 8) begin
            upd = UPD_W'($urandom_range(200, 0)) - 16'sd100;
        end else begin
            case ($urandom_range(3, 0))
                0:       upd = 16'sh7FFF;
                1:       upd = 16'sh8000;
                2:       upd = 16'sh0000;
                default: upd = 16'shFFFF;
            endcase
        end
        offer_item(sid, key, upd, max_gap, 1'b0, '0);
    endtask

    // write only once the block has gone quiet
    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        start <= 1'b0;
        while (pending_joins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FIRST_STREAM) begin
            cfg_first_sid = data;
        end else if (idx == CFG_SECOND_STREAM) begin
            cfg_second_sid = data;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_join_res want;
        if (i_rst_n && o_valid) begin
            if (pending_joins.size() == 0) begin
                $display("%0t: unexpected result join_size %0d matched %0b",
                         $time, o_join_size, o_matched);
                errors++;
            end else begin
                want = pending_joins.pop_front();
                if (o_join_size !== want.join_size) begin
                    $display("%0t: join_size expected %0d actual %0d",
                             $time, want.join_size, o_join_size);
                    errors++;
                end
                if (o_matched !== want.matched) begin
                    $display("%0t: matched expected %0b actual %0b",
                             $time, want.matched, o_matched);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        t_join_res typed_res;
        int        gap_max;
        errors         = 0;
        cfg_first_sid  = FIRST_STREAM_RST;
        cfg_second_sid = SECOND_STREAM_RST;
        join_est       = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            first_freq[k]  = '0;
            second_freq[k] = '0;
        end
        for (int k = 0; k < N_HOT_KEYS; k++) begin
            hot_keys[k] = KEY_W'($urandom);
        end

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        i_stream_id <= '0;
        i_key       <= '0;
        i_update    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the clearing pass keeps busy high; the first item simply waits
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].kind == ROW_CFG) begin
                write_reg(PLAN[r].reg_idx, PLAN[r].reg_data);
            end else begin
                typed_res.join_size = PLAN[r].exp_join;
                typed_res.matched   = PLAN[r].exp_matched;
                offer_item(PLAN[r].sid, PLAN[r].key, PLAN[r].upd, 5,
                           PLAN[r].typed, typed_res);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_FIRST_STREAM, PHASE_FIRST[p]);
            write_reg(CFG_SECOND_STREAM, PHASE_SECOND[p]);
            if ($urandom_range(1, 0) == 1) begin
                write_reg(CFG_IDX_W'($urandom_range(255, 2)), CFG_DATA_W'($urandom));
            end
            gap_max = 5;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    gap_max = ($urandom_range(3, 0) == 0) ? 0 : 5;
                end
                offer_random_item(gap_max);
            end
        end

        // finish with ordinary traffic under the last setting
        for (int n = 0; n < TAIL_ITEMS; n++) begin
            offer_random_item(5);
        end

        start <= 1'b0;
        while (pending_joins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
